FILE: src/bps_pkg.sv
`default_nettype none

package bps_pkg;

	// significant bits taken from each 16-bit channel slot
	localparam int unsigned CHANNEL_BITS = 16;
	localparam int unsigned CH_W         = 16;
	localparam int unsigned NUM_CH       = 3;
	localparam int unsigned PIX_W        = CH_W * NUM_CH;
	localparam int unsigned WGT_W        = 16;
	localparam int unsigned PROD_W       = CH_W + WGT_W;
	localparam int unsigned FRAC_SHIFT   = 15;

	localparam logic [CH_W-1:0]   CH_MASK     = CH_W'((32'd1 << CHANNEL_BITS) - 32'd1);
	localparam logic [WGT_W-1:0]  WEIGHT_ONE  = WGT_W'(32768);
	localparam logic [PROD_W-1:0] ROUND_BIAS  = PROD_W'(16384);
	localparam logic [8:0]        FRAC_ONE    = 9'd256;

	localparam int unsigned CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IMAGE_WIDTH  = 2'd0,
		CFG_IMAGE_HEIGHT = 2'd1,
		CFG_FAST_NEAREST = 2'd2
	} cfg_idx_t;

	typedef logic [NUM_CH-1:0][CH_W-1:0] pix_t;
	typedef logic [NUM_CH-1:0][PROD_W-1:0] prod_t;

	// the four bilinear weights, already zeroed for black neighbors
	typedef struct packed {
		logic [WGT_W-1:0] a;
		logic [WGT_W-1:0] b;
		logic [WGT_W-1:0] c;
		logic [WGT_W-1:0] d;
	} weights_t;

	function automatic pix_t unpack_pix(input logic [PIX_W-1:0] px);
		pix_t r;
		for (int k = 0; k < NUM_CH; k++) begin
			r[k] = px[k*CH_W +: CH_W] & CH_MASK;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: src/bilinear_pixel_sampler_core.sv
`default_nettype none

// bilinear / nearest pixel sampler
// input: pulse start with sample_x, sample_y (signed 16.16) and the four
// neighbor pixels (16 bits per channel, red in the low slot); an item is taken
// at every edge with start high and busy low. busy is always low, so a new
// item can enter in every cycle.
// output: red, green, blue and write_enable are valid for the single cycle in
// which done is high; done follows valid_s1 and valid_s2, one result
// per item, in order. the receiver cannot stall, and nothing inside stalls.
// stage 1 decodes the position, runs the border tests and forms the four
// 1.15 weights; stage 2 does the twelve channel-by-weight products;
// stage 3 adds them with the rounding bias and registers the result.
// config: cfg_we writes cfg_data into register cfg_index (0 width, 1 height,
// 2 nearest mode), to be done while no item is in flight.
// reset: arst_n clears the pipeline valid bits and sets width and height
// to 2 and the mode to bilinear.
module bilinear_pixel_sampler_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [bps_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [15:0]                         cfg_data,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic signed [31:0]                  sample_x,
	input  wire logic signed [31:0]                  sample_y,
	input  wire logic [bps_pkg::PIX_W-1:0]           pixel_top_left,
	input  wire logic [bps_pkg::PIX_W-1:0]           pixel_top_right,
	input  wire logic [bps_pkg::PIX_W-1:0]           pixel_bottom_left,
	input  wire logic [bps_pkg::PIX_W-1:0]           pixel_bottom_right,
	output logic                                     done,
	output logic [bps_pkg::CH_W-1:0]                 red,
	output logic [bps_pkg::CH_W-1:0]                 green,
	output logic [bps_pkg::CH_W-1:0]                 blue,
	output logic                                     write_enable
);

	logic [15:0] width_q;
	logic [15:0] height_q;
	logic        nearest_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= 16'd2;
			height_q  <= 16'd2;
			nearest_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				bps_pkg::CFG_IMAGE_WIDTH:  width_q   <= cfg_data;
				bps_pkg::CFG_IMAGE_HEIGHT: height_q  <= cfg_data;
				bps_pkg::CFG_FAST_NEAREST: nearest_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// ---------------- stage 1: border tests and weights
	logic signed [17:0] ix, iy, w_e, h_e, wm1, hm1;
	logic               x_left, y_top, x_right, y_bottom;
	logic               x_far, y_far, far_out, near_out;
	logic [7:0]         fx, fy;
	logic [8:0]         gx, gy;
	logic [17:0]        pa_w, pb_w, pc_w, pd_w;
	bps_pkg::weights_t  wgt;

	always_comb begin
		ix  = {{2{sample_x[31]}}, sample_x[31:16]};
		iy  = {{2{sample_y[31]}}, sample_y[31:16]};
		w_e = signed'({2'b00, width_q});
		h_e = signed'({2'b00, height_q});
		wm1 = w_e - 18'sd1;
		hm1 = h_e - 18'sd1;

		x_left   = ix < 18'sd0;
		y_top    = iy < 18'sd0;
		x_right  = ix >= wm1;
		y_bottom = iy >= hm1;
		x_far    = (ix < -18'sd1) || (ix >= w_e);
		y_far    = (iy < -18'sd1) || (iy >= h_e);
		far_out  = x_far || y_far;
		near_out = x_left || y_top || x_right || y_bottom;

		fx = sample_x[15:8];
		fy = sample_y[15:8];
		gx = bps_pkg::FRAC_ONE - {1'b0, fx};
		gy = bps_pkg::FRAC_ONE - {1'b0, fy};
		pa_w = gx * gy;
		pb_w = {1'b0, fx} * gy;
		pc_w = gx * {1'b0, fy};
		pd_w = {1'b0, fx} * {1'b0, fy};

		wgt = '0;
		if (nearest_q) begin
			// full weight on top-left reproduces it exactly after rounding
			if (!near_out) wgt.a = bps_pkg::WEIGHT_ONE;
		end else if (!far_out) begin
			if (!x_left && !y_top)     wgt.a = pa_w[16:1];
			if (!x_right && !y_top)    wgt.b = pb_w[16:1];
			if (!x_left && !y_bottom)  wgt.c = pc_w[16:1];
			if (!x_right && !y_bottom) wgt.d = pd_w[16:1];
		end
	end

	logic              valid_s1;
	logic              we_s1;
	bps_pkg::weights_t wgt_s1;
	bps_pkg::pix_t     pa_s1, pb_s1, pc_s1, pd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			we_s1  <= nearest_q || !far_out;
			wgt_s1 <= wgt;
			pa_s1  <= bps_pkg::unpack_pix(pixel_top_left);
			pb_s1  <= bps_pkg::unpack_pix(pixel_top_right);
			pc_s1  <= bps_pkg::unpack_pix(pixel_bottom_left);
			pd_s1  <= bps_pkg::unpack_pix(pixel_bottom_right);
		end
	end

	// ---------------- stage 2: channel products
	logic          valid_s2;
	logic          we_s2;
	bps_pkg::prod_t prod_a_s2, prod_b_s2, prod_c_s2, prod_d_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			we_s2 <= we_s1;
			for (int k = 0; k < bps_pkg::NUM_CH; k++) begin
				prod_a_s2[k] <= pa_s1[k] * wgt_s1.a;
				prod_b_s2[k] <= pb_s1[k] * wgt_s1.b;
				prod_c_s2[k] <= pc_s1[k] * wgt_s1.c;
				prod_d_s2[k] <= pd_s1[k] * wgt_s1.d;
			end
		end
	end

	// ---------------- stage 3: sum, round, output
	// weights sum to at most one, so the total stays below 2^31
	bps_pkg::prod_t acc;
	always_comb begin
		for (int k = 0; k < bps_pkg::NUM_CH; k++) begin
			acc[k] = prod_a_s2[k] + prod_b_s2[k] + prod_c_s2[k] + prod_d_s2[k]
				+ bps_pkg::ROUND_BIAS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done         <= 1'b0;
			write_enable <= 1'b0;
		end else begin
			done         <= valid_s2;
			write_enable <= valid_s2 && we_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			red   <= acc[0][bps_pkg::FRAC_SHIFT +: bps_pkg::CH_W];
			green <= acc[1][bps_pkg::FRAC_SHIFT +: bps_pkg::CH_W];
			blue  <= acc[2][bps_pkg::FRAC_SHIFT +: bps_pkg::CH_W];
		end
	end

endmodule

`default_nettype wire

FILE: src/bps_checker.sv
`default_nettype none

module bps_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic [15:0] red,
	input wire logic [15:0] green,
	input wire logic [15:0] blue,
	input wire logic        write_enable
);

	// counts cycles since reset so that look-backs never reach into reset
	logic [1:0] warm_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warm_q <= 2'd0;
		end else if (warm_q != 2'd3) begin
			warm_q <= warm_q + 2'd1;
		end
	end

	a_item_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done)
		else $error("accepted item gave no result three cycles later");

	a_no_spurious_result: assert property (@(posedge clk) disable iff (!arst_n)
		(done && warm_q == 2'd3) |-> $past(start && !busy, 3))
		else $error("result without a matching item");

	a_write_only_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> !write_enable)
		else $error("write_enable outside a result cycle");

	a_no_write_is_black: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !write_enable) |-> (red == 16'd0 && green == 16'd0 && blue == 16'd0))
		else $error("suppressed write carries a nonzero pixel");

endmodule

bind bilinear_pixel_sampler_core bps_checker u_bps_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.red          (red),
	.green        (green),
	.blue         (blue),
	.write_enable (write_enable)
);

`default_nettype wire

FILE: verif/bps_sample_checker.sv
`default_nettype none

module bps_sample_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [bps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [15:0]                   cfg_data,
	input  wire logic                          start,
	input  wire logic                          busy,
	input  wire logic signed [31:0]            sample_x,
	input  wire logic signed [31:0]            sample_y,
	input  wire logic [bps_pkg::PIX_W-1:0]     pixel_top_left,
	input  wire logic [bps_pkg::PIX_W-1:0]     pixel_top_right,
	input  wire logic [bps_pkg::PIX_W-1:0]     pixel_bottom_left,
	input  wire logic [bps_pkg::PIX_W-1:0]     pixel_bottom_right,
	input  wire logic                          done,
	input  wire logic [bps_pkg::CH_W-1:0]      red,
	input  wire logic [bps_pkg::CH_W-1:0]      green,
	input  wire logic [bps_pkg::CH_W-1:0]      blue,
	input  wire logic                          write_enable,
	output int                                 mismatches,
	output int                                 in_flight
);

	typedef struct packed {
		logic [bps_pkg::CH_W-1:0] red;
		logic [bps_pkg::CH_W-1:0] green;
		logic [bps_pkg::CH_W-1:0] blue;
		logic                     we;
	} rgb_out_t;

	logic [15:0] cur_width;
	logic [15:0] cur_height;
	logic        cur_nearest;
	rgb_out_t    expected_pixels[$];

	initial mismatches = 0;
	initial in_flight = 0;

	task automatic report(input string what, input logic [15:0] want, input logic [15:0] got);
		$display("sampler mismatch: %s expected %h got %h at %0t", what, want, got, $time);
		mismatches++;
	endtask

	function automatic logic [15:0] channel(input logic [bps_pkg::PIX_W-1:0] px, input int k);
		return px[k*bps_pkg::CH_W +: bps_pkg::CH_W] & bps_pkg::CH_MASK;
	endfunction

	function automatic rgb_out_t sample_pixel(
		input logic signed [31:0] sx,
		input logic signed [31:0] sy,
		input logic [bps_pkg::PIX_W-1:0] tl,
		input logic [bps_pkg::PIX_W-1:0] tr,
		input logic [bps_pkg::PIX_W-1:0] bl,
		input logic [bps_pkg::PIX_W-1:0] br
	);
		rgb_out_t r;
		int ix, iy, w, h;
		int fx, fy, gx, gy;
		int wa, wb, wc, wd;
		bit ka, kb, kc, kd;
		longint acc;
		logic [15:0] ch[3];
		ix = int'($signed(sx[31:16]));
		iy = int'($signed(sy[31:16]));
		w = int'(cur_width);
		h = int'(cur_height);
		r = '0;
		if (cur_nearest) begin
			r.we = 1'b1;
			if (ix < 0 || iy < 0 || ix >= w - 1 || iy >= h - 1)
				return r;
			r.red = channel(tl, 0);
			r.green = channel(tl, 1);
			r.blue = channel(tl, 2);
			return r;
		end
		// more than one pixel outside: nothing is written
		if (ix < -1 || iy < -1 || ix >= w || iy >= h)
			return r;
		fx = int'(sx[15:8]);
		fy = int'(sy[15:8]);
		gx = int'(bps_pkg::FRAC_ONE) - fx;
		gy = int'(bps_pkg::FRAC_ONE) - fy;
		wa = (gx * gy) >> 1;
		wb = (fx * gy) >> 1;
		wc = (gx * fy) >> 1;
		wd = (fx * fy) >> 1;
		ka = !(ix < 0 || iy < 0);
		kb = !(iy < 0 || ix >= w - 1);
		kc = !(ix < 0 || iy >= h - 1);
		kd = !(ix >= w - 1 || iy >= h - 1);
		for (int k = 0; k < 3; k++) begin
			acc = longint'(bps_pkg::ROUND_BIAS);
			if (ka) acc += longint'(channel(tl, k)) * wa;
			if (kb) acc += longint'(channel(tr, k)) * wb;
			if (kc) acc += longint'(channel(bl, k)) * wc;
			if (kd) acc += longint'(channel(br, k)) * wd;
			ch[k] = 16'(acc >> bps_pkg::FRAC_SHIFT);
		end
		r.red = ch[0];
		r.green = ch[1];
		r.blue = ch[2];
		r.we = 1'b1;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rgb_out_t want;
		if (!arst_n) begin
			expected_pixels.delete();
			cur_width = 16'd2;
			cur_height = 16'd2;
			cur_nearest = 1'b0;
			in_flight = 0;
		end else begin
			if (done) begin
				if (expected_pixels.size() == 0) begin
					report("result with no item pending, red", 16'h0, red);
				end else begin
					want = expected_pixels.pop_front();
					if (red !== want.red) report("red", want.red, red);
					if (green !== want.green) report("green", want.green, green);
					if (blue !== want.blue) report("blue", want.blue, blue);
					if (write_enable !== want.we)
						report("write_enable", 16'(want.we), 16'(write_enable));
				end
			end
			if (start && !busy)
				expected_pixels.push_back(sample_pixel(sample_x, sample_y, pixel_top_left,
					pixel_top_right, pixel_bottom_left, pixel_bottom_right));
			if (cfg_we) begin
				case (cfg_index)
					bps_pkg::CFG_IMAGE_WIDTH: cur_width = cfg_data;
					bps_pkg::CFG_IMAGE_HEIGHT: cur_height = cfg_data;
					bps_pkg::CFG_FAST_NEAREST: cur_nearest = cfg_data[0];
					default: ;
				endcase
			end
			in_flight = expected_pixels.size();
		end
	end

endmodule

`default_nettype wire

FILE: verif/tb_bilinear_pixel_sampler_core.sv
`default_nettype none

module tb_bilinear_pixel_sampler_core;

	localparam logic [bps_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
	localparam int RANDOM_PHASES = 12;
	localparam int ITEMS_PER_PHASE = 60;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [bps_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [15:0]                   cfg_data;
	logic                          start;
	wire logic                     busy;
	logic signed [31:0]            sample_x;
	logic signed [31:0]            sample_y;
	logic [bps_pkg::PIX_W-1:0]     pixel_top_left;
	logic [bps_pkg::PIX_W-1:0]     pixel_top_right;
	logic [bps_pkg::PIX_W-1:0]     pixel_bottom_left;
	logic [bps_pkg::PIX_W-1:0]     pixel_bottom_right;
	wire logic                     done;
	wire logic [bps_pkg::CH_W-1:0] red;
	wire logic [bps_pkg::CH_W-1:0] green;
	wire logic [bps_pkg::CH_W-1:0] blue;
	wire logic                     write_enable;
	int                            mismatches;
	int                            in_flight;

	bilinear_pixel_sampler_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.start(start),
		.busy(busy),
		.sample_x(sample_x),
		.sample_y(sample_y),
		.pixel_top_left(pixel_top_left),
		.pixel_top_right(pixel_top_right),
		.pixel_bottom_left(pixel_bottom_left),
		.pixel_bottom_right(pixel_bottom_right),
		.done(done),
		.red(red),
		.green(green),
		.blue(blue),
		.write_enable(write_enable)
	);

	bps_sample_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.start(start),
		.busy(busy),
		.sample_x(sample_x),
		.sample_y(sample_y),
		.pixel_top_left(pixel_top_left),
		.pixel_top_right(pixel_top_right),
		.pixel_bottom_left(pixel_bottom_left),
		.pixel_bottom_right(pixel_bottom_right),
		.done(done),
		.red(red),
		.green(green),
		.blue(blue),
		.write_enable(write_enable),
		.mismatches(mismatches),
		.in_flight(in_flight)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("tb_bilinear_pixel_sampler_core: done, errors");
		$finish;
	end

	function automatic logic [bps_pkg::PIX_W-1:0] rand_pixel();
		logic [63:0] r;
		r = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0: r = '1;
			1: r = '0;
			default: ;
		endcase
		return r[bps_pkg::PIX_W-1:0];
	endfunction

	// integer part clustered around the image borders, fraction random
	function automatic logic [31:0] pick_coord(input int unsigned extent);
		int ip;
		logic [15:0] frac;
		int unsigned sel;
		sel = $urandom_range(0, 15);
		frac = 16'($urandom);
		if ($urandom_range(0, 7) == 0)
			frac = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
		if (sel == 0)
			return $urandom;
		if (sel < 6) begin
			case ($urandom_range(0, 6))
				0: ip = -2;
				1: ip = -1;
				2: ip = 0;
				3: ip = int'(extent) - 2;
				4: ip = int'(extent) - 1;
				5: ip = int'(extent);
				default: ip = int'(extent) + 1;
			endcase
		end else begin
			ip = int'($urandom_range(0, extent + 2)) - 2;
		end
		return {ip[15:0], frac};
	endfunction

	function automatic int pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic write_reg(input logic [bps_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [15:0] w, input logic [15:0] h, input logic nearest);
		write_reg(bps_pkg::CFG_IMAGE_WIDTH, w);
		write_reg(bps_pkg::CFG_IMAGE_HEIGHT, h);
		// upper bits of the mode register are don't-care
		write_reg(bps_pkg::CFG_FAST_NEAREST, {15'($urandom), nearest});
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		start <= 1'b0;
		// look at the count only once the edge's bookkeeping has settled
		do @(negedge clk); while (in_flight != 0);
		@(posedge clk);
	endtask

	task automatic apply(
		input logic [31:0] sx,
		input logic [31:0] sy,
		input logic [bps_pkg::PIX_W-1:0] tl,
		input logic [bps_pkg::PIX_W-1:0] tr,
		input logic [bps_pkg::PIX_W-1:0] bl,
		input logic [bps_pkg::PIX_W-1:0] br,
		input bit allow_gap
	);
		int gap;
		start <= 1'b1;
		sample_x <= sx;
		sample_y <= sy;
		pixel_top_left <= tl;
		pixel_top_right <= tr;
		pixel_bottom_left <= bl;
		pixel_bottom_right <= br;
		do @(posedge clk); while (busy);
		gap = allow_gap ? pick_gap() : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic apply_flat(input logic [31:0] sx, input logic [31:0] sy,
			input logic [bps_pkg::PIX_W-1:0] px);
		apply(sx, sy, px, px, px, px, 1'b1);
	endtask

	task automatic apply_rand(input logic [31:0] sx, input logic [31:0] sy, input bit allow_gap);
		apply(sx, sy, rand_pixel(), rand_pixel(), rand_pixel(), rand_pixel(), allow_gap);
	endtask

	initial begin
		int unsigned w, h;
		bit nearest;
		bit no_idle;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		start = 1'b0;
		sample_x = '0;
		sample_y = '0;
		pixel_top_left = '0;
		pixel_top_right = '0;
		pixel_bottom_left = '0;
		pixel_bottom_right = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// bilinear on the reset 2x2 image: interior, each border, far outside
		apply_flat(32'h0000_0000, 32'h0000_0000, '1);
		apply_rand(32'h0000_8000, 32'h0000_8000, 1'b1);
		apply_flat(32'h0000_ffff, 32'h0000_ffff, '1);
		apply_rand(32'hffff_8000, 32'h0000_4000, 1'b1);
		apply_rand(32'h0000_4000, 32'hffff_8000, 1'b1);
		apply_rand(32'h0001_c000, 32'h0000_2000, 1'b1);
		apply_rand(32'h0000_3000, 32'h0001_ff00, 1'b1);
		apply_flat(32'hffff_ffff, 32'hffff_ffff, '1);
		apply_rand(32'hfffe_0000, 32'h0000_0000, 1'b1);
		apply_rand(32'h0002_0000, 32'h0000_0000, 1'b1);
		apply_rand(32'h0000_0000, 32'hfffe_0000, 1'b1);
		apply_rand(32'h0000_0000, 32'h0002_ffff, 1'b1);
		apply_flat(32'h7fff_ffff, 32'h8000_0000, '0);

		// nearest mode, inside and outside to the left, right and bottom
		drain();
		set_config(16'd2, 16'd2, 1'b1);
		apply_rand(32'h0000_8000, 32'h0000_8000, 1'b1);
		apply_rand(32'hffff_8000, 32'h0000_0000, 1'b1);
		apply_rand(32'h0001_0000, 32'h0000_0000, 1'b1);
		apply_rand(32'h0000_0000, 32'h0001_0000, 1'b1);
		apply_rand(32'h8000_0000, 32'h7fff_ffff, 1'b1);

		// tiny image, plus a write to the unmapped index
		drain();
		write_reg(CFG_IDX_SPARE, 16'hffff);
		set_config(16'd1, 16'd0, 1'b0);
		apply_rand(32'h0000_0000, 32'h0000_0000, 1'b1);
		apply_rand(32'hffff_8000, 32'hffff_8000, 1'b1);

		// largest image
		drain();
		set_config(16'hffff, 16'hffff, 1'b0);
		apply_rand(32'h7fff_8080, 32'h7fff_ffff, 1'b1);
		apply_rand(32'h1234_5678, 32'h0000_abcd, 1'b1);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: begin w = 2; h = 2; nearest = 0; end
				1: begin w = 3; h = 5; nearest = 0; end
				2: begin w = 16; h = 9; nearest = 0; end
				3: begin w = 65535; h = 65535; nearest = 0; end
				4: begin w = 1; h = 0; nearest = 0; end
				5: begin w = 640; h = 480; nearest = 1; end
				6: begin w = 2; h = 2; nearest = 1; end
				7: begin w = 100; h = 65535; nearest = 0; end
				8: begin w = 65535; h = 3; nearest = 1; end
				9: begin w = 0; h = 65535; nearest = 1; end
				default: begin
					w = $urandom_range(2, 300);
					h = $urandom_range(2, 300);
					nearest = $urandom_range(0, 1);
				end
			endcase
			drain();
			set_config(16'(w), 16'(h), nearest);
			no_idle = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				// hold off until the pipeline is empty, then resume mid-phase
				if (p == 5 && i == ITEMS_PER_PHASE / 2)
					drain();
				apply_rand(pick_coord(w), pick_coord(h), !no_idle);
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb_bilinear_pixel_sampler_core: done, clean");
		end else begin
			$display("tb_bilinear_pixel_sampler_core: done, errors");
		end
		$finish;
	end

endmodule

`default_nettype wire

FILE: files.f
src/bps_pkg.sv
src/bilinear_pixel_sampler_core.sv
src/bps_checker.sv
verif/bps_sample_checker.sv
verif/tb_bilinear_pixel_sampler_core.sv
